// ===== rtl/u8sv_pkg.sv =====
package u8sv_pkg;

  // byte classes as seen in lead position
  localparam logic [2:0] CLS_ASCII = 3'd0;
  localparam logic [2:0] CLS_ZERO  = 3'd1;
  localparam logic [2:0] CLS_LEAD2 = 3'd2;
  localparam logic [2:0] CLS_LEAD3 = 3'd3;
  localparam logic [2:0] CLS_LEAD4 = 3'd4;
  localparam logic [2:0] CLS_BAD   = 3'd5;

  localparam logic [1:0] MIN_2BYTE = 2'd1;
  localparam logic [1:0] MIN_3BYTE = 2'd2;
  localparam logic [1:0] MIN_4BYTE = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int CPW = 21;

  localparam logic [CPW-1:0] CP_MAX      = 21'h10ffff;
  localparam logic [CPW-1:0] SURR_LO     = 21'h00d800;
  localparam logic [CPW-1:0] SURR_HI     = 21'h00dfff;

  typedef struct packed {
    logic [2:0] cls;
    logic       cont;
    logic [5:0] bits;
    logic       last;
  } item_t;

  function automatic logic [CPW-1:0] class_min(input logic [1:0] minc);
    logic [CPW-1:0] m;
    case (minc)
      MIN_2BYTE: m = 21'h000080;
      MIN_3BYTE: m = 21'h000800;
      default:   m = 21'h010000;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/u8sv_front.sv =====
module u8sv_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     text_byte,
  input  logic           end_of_message,
  output logic           q_valid,
  output u8sv_pkg::item_t q_item,
  input  logic           q_take
);

  u8sv_pkg::item_t                  mem [u8sv_pkg::QDEPTH];
  logic [u8sv_pkg::QAW-1:0]         wr_ptr;
  logic [u8sv_pkg::QAW-1:0]         rd_ptr;
  logic [u8sv_pkg::QCW-1:0]         count;
  u8sv_pkg::item_t                  cls_item;
  logic                             wr_en;

  always_comb begin
    cls_item.cont = (text_byte[7:6] == 2'b10);
    cls_item.bits = text_byte[5:0];
    cls_item.last = end_of_message;
    if (text_byte == 8'h00) begin
      cls_item.cls = u8sv_pkg::CLS_ZERO;
    end else if (!text_byte[7]) begin
      cls_item.cls = u8sv_pkg::CLS_ASCII;
    end else if (text_byte[7:5] == 3'b110) begin
      cls_item.cls = u8sv_pkg::CLS_LEAD2;
    end else if (text_byte[7:4] == 4'b1110) begin
      cls_item.cls = u8sv_pkg::CLS_LEAD3;
    end else if (text_byte[7:3] == 5'b11110) begin
      cls_item.cls = u8sv_pkg::CLS_LEAD4;
    end else begin
      cls_item.cls = u8sv_pkg::CLS_BAD;
    end
  end

  assign full    = (count == u8sv_pkg::QCW'(u8sv_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign wr_en   = push && !full;
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, q_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/u8sv_back.sv =====
module u8sv_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  u8sv_pkg::item_t q_item,
  output logic            q_take,
  output logic            empty,
  input  logic            pop,
  output logic            message_valid
);

  logic [1:0]                 pending, pending_next;
  logic [u8sv_pkg::CPW-1:0]   acc, acc_next;
  logic [1:0]                 minc, minc_next;
  logic                       err, err_next;
  logic                       res_bit;

  // two-entry result queue
  logic [1:0] rq;
  logic       rq_wr_ptr;
  logic       rq_rd_ptr;
  logic [1:0] rq_count;
  logic       rq_pop;
  logic       rq_push;

  assign empty         = (rq_count == 2'd0);
  assign rq_pop        = pop && !empty;
  assign q_take        = q_valid && ((rq_count != 2'd2) || rq_pop);
  assign rq_push       = q_take && q_item.last;
  assign message_valid = rq[rq_rd_ptr];

  always_comb begin
    pending_next = pending;
    acc_next     = acc;
    minc_next    = minc;
    err_next     = err;
    if (pending == 2'd0) begin
      case (q_item.cls)
        u8sv_pkg::CLS_ASCII: ;
        u8sv_pkg::CLS_ZERO:  err_next = 1'b1;
        u8sv_pkg::CLS_LEAD2: begin
          pending_next = 2'd1;
          acc_next     = {16'd0, q_item.bits[4:0]};
          minc_next    = u8sv_pkg::MIN_2BYTE;
        end
        u8sv_pkg::CLS_LEAD3: begin
          pending_next = 2'd2;
          acc_next     = {17'd0, q_item.bits[3:0]};
          minc_next    = u8sv_pkg::MIN_3BYTE;
        end
        u8sv_pkg::CLS_LEAD4: begin
          pending_next = 2'd3;
          acc_next     = {18'd0, q_item.bits[2:0]};
          minc_next    = u8sv_pkg::MIN_4BYTE;
        end
        default: err_next = 1'b1;
      endcase
    end else begin
      if (!q_item.cont) begin
        err_next = 1'b1;
      end
      acc_next     = {acc[u8sv_pkg::CPW-7:0], q_item.bits};
      pending_next = pending - 2'd1;
      // range checks once the sequence is complete
      if (pending_next == 2'd0) begin
        if ((acc_next < u8sv_pkg::class_min(minc)) || (acc_next > u8sv_pkg::CP_MAX) ||
            (acc_next inside {[u8sv_pkg::SURR_LO:u8sv_pkg::SURR_HI]})) begin
          err_next = 1'b1;
        end
      end
    end
    res_bit = !err_next && (pending_next == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      acc     <= '0;
      minc    <= '0;
      err     <= 1'b0;
    end else if (q_take) begin
      if (q_item.last) begin
        pending <= '0;
        acc     <= '0;
        minc    <= '0;
        err     <= 1'b0;
      end else begin
        pending <= pending_next;
        acc     <= acc_next;
        minc    <= minc_next;
        err     <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq[rq_wr_ptr] <= res_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr_ptr <= 1'b0;
      rq_rd_ptr <= 1'b0;
      rq_count  <= '0;
    end else begin
      if (rq_push) begin
        rq_wr_ptr <= ~rq_wr_ptr;
      end
      if (rq_pop) begin
        rq_rd_ptr <= ~rq_rd_ptr;
      end
      case ({rq_push, rq_pop})
        2'b10:   rq_count <= rq_count + 2'd1;
        2'b01:   rq_count <= rq_count - 2'd1;
        default: rq_count <= rq_count;
      endcase
    end
  end

endmodule

// ===== rtl/utf8_stream_validator.sv =====
// Strict UTF-8 checker for byte streams. Push one byte per clock with
// end_of_message high on the final byte; one message_valid result per message
// appears on the result queue, 1 when the message is well-formed UTF-8 with no
// zero byte, no overlong form, no surrogate and nothing above 0x10FFFF. The
// block sustains one byte per clock while the result queue has room: the front
// classifies each byte into a four-entry queue and the back decoder consumes
// one queued byte per cycle. A result enters the result queue when the decoder
// takes the final byte. The input goes full only when the result queue (two
// entries) is not drained and the byte queue fills behind it.
module utf8_stream_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic       message_valid
);

  logic            q_valid;
  logic            q_take;
  u8sv_pkg::item_t q_item;

  u8sv_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .text_byte      (text_byte),
    .end_of_message (end_of_message),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_take         (q_take)
  );

  u8sv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_take        (q_take),
    .empty         (empty),
    .pop           (pop),
    .message_valid (message_valid)
  );

  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("decoder took from an empty byte queue");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_full_has_item: assert property (@(posedge clk) disable iff (rst)
    full |-> q_valid)
    else $error("byte queue full but nothing offered to decoder");

endmodule

// ===== test/tb_utf8_stream_validator.sv =====
`timescale 1ns / 100ps

module tb_utf8_stream_validator;

  // smallest legal value of the open multi-byte sequence
  typedef enum logic [1:0] {
    MIN_NONE = 2'd0,
    MIN_80   = 2'd1,
    MIN_800  = 2'd2,
    MIN_10K  = 2'd3
  } min_class_t;

  typedef enum int {
    RX_FREE,
    RX_PATTERN
  } rx_mode_t;

  localparam logic [20:0] CP_TOP     = 21'h10ffff;
  localparam logic [20:0] SURR_FIRST = 21'h00d800;
  localparam logic [20:0] SURR_LAST  = 21'h00dfff;
  localparam int          HOLD_LEN   = 200;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] text_byte;
  logic       end_of_message;
  logic       empty;
  logic       pop;
  logic       message_valid;

  utf8_stream_validator DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .text_byte(text_byte),
    .end_of_message(end_of_message),
    .empty(empty),
    .pop(pop),
    .message_valid(message_valid)
  );

  // decoder state mirrored for prediction
  logic [1:0]  pend_cnt;
  logic [20:0] cp_acc;
  min_class_t  min_sel;
  bit          err_flag;
  bit          verdict_q[$];

  logic [7:0]  msg_q[$];

  int       fail_count;
  int       bytes_sent;
  int       msgs_sent;
  int       verdicts_checked;
  int       stall_cycles;
  int       burst_left;
  bit       gaps_on;
  bit       offering;
  rx_mode_t rx_mode;
  int       hold_seq;
  int       hold_ack;
  int       hold_left;
  logic [15:0] rx_pattern = 16'ha5c3;
  logic [4:0]  rx_tick = 5'd0;
  bit          expected_verdict;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // per-byte decode; queues a verdict on the final byte of a message
  task automatic decode_byte(input logic [7:0] b, input bit last);
    logic [20:0] floor_cp;
    if (pend_cnt == 2'd0) begin
      if (b == 8'h00) begin
        err_flag = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        pend_cnt = 2'd1;
        cp_acc   = {16'd0, b[4:0]};
        min_sel  = MIN_80;
      end else if (b[7:4] == 4'b1110) begin
        pend_cnt = 2'd2;
        cp_acc   = {17'd0, b[3:0]};
        min_sel  = MIN_800;
      end else if (b[7:3] == 5'b11110) begin
        pend_cnt = 2'd3;
        cp_acc   = {18'd0, b[2:0]};
        min_sel  = MIN_10K;
      end else if (b[7]) begin
        err_flag = 1'b1;
      end
    end else begin
      // a bad continuation is still folded in, the error sticks anyway
      if (b[7:6] != 2'b10) err_flag = 1'b1;
      cp_acc   = {cp_acc[14:0], b[5:0]};
      pend_cnt = pend_cnt - 2'd1;
      if (pend_cnt == 2'd0) begin
        case (min_sel)
          MIN_80:  floor_cp = 21'h000080;
          MIN_800: floor_cp = 21'h000800;
          default: floor_cp = 21'h010000;
        endcase
        if (cp_acc < floor_cp || cp_acc > CP_TOP ||
            (cp_acc inside {[SURR_FIRST:SURR_LAST]}))
          err_flag = 1'b1;
      end
    end
    if (last) begin
      verdict_q.push_back(!err_flag && pend_cnt == 2'd0);
      pend_cnt = 2'd0;
      cp_acc   = 21'd0;
      min_sel  = MIN_NONE;
      err_flag = 1'b0;
    end
  endtask

  // one byte transfer; called right after a rising edge
  task automatic send_byte(input logic [7:0] b, input bit last);
    text_byte      <= b;
    end_of_message <= last;
    push           <= 1'b1;
    offering = 1'b1;
    @(posedge clk);
    while (full) begin
      stall_cycles++;
      @(posedge clk);
    end
    decode_byte(b, last);
    bytes_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        push <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(9, 1)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++)
      send_byte(msg_q[i], i == msg_q.size() - 1);
    msgs_sent++;
  endtask

  task automatic append_cp(input logic [20:0] cp, input int nb);
    case (nb)
      1: msg_q.push_back(cp[7:0]);
      2: begin
        msg_q.push_back({3'b110, cp[10:6]});
        msg_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        msg_q.push_back({4'b1110, cp[15:12]});
        msg_q.push_back({2'b10, cp[11:6]});
        msg_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        msg_q.push_back({5'b11110, cp[20:18]});
        msg_q.push_back({2'b10, cp[17:12]});
        msg_q.push_back({2'b10, cp[11:6]});
        msg_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic append_good_char();
    logic [20:0] cp;
    case ($urandom_range(3, 0))
      0: append_cp(21'($urandom_range(21'h7f, 21'h01)), 1);
      1: append_cp(21'($urandom_range(21'h7ff, 21'h80)), 2);
      2: begin
        cp = 21'($urandom_range(21'hffff, 21'h800));
        while (cp inside {[SURR_FIRST:SURR_LAST]})
          cp = 21'($urandom_range(21'hffff, 21'h800));
        append_cp(cp, 3);
      end
      default: append_cp(21'($urandom_range(CP_TOP, 21'h10000)), 4);
    endcase
  endtask

  // mostly well-formed text, some messages with one flaw, some noise
  task automatic build_message(input int max_chars);
    int          nb;
    logic [20:0] floor_cp;
    msg_q.delete();
    repeat ($urandom_range(max_chars, 1)) append_good_char();
    case ($urandom_range(15, 0))
      0: begin
        nb = $urandom_range(4, 2);
        floor_cp = (nb == 2) ? 21'h80 : (nb == 3) ? 21'h800 : 21'h10000;
        append_cp($urandom_range(1, 0) ? floor_cp - 21'd1
                                       : 21'($urandom_range(floor_cp - 21'd1, 0)), nb);
        if ($urandom_range(1, 0)) append_good_char();
      end
      1: begin
        append_cp($urandom_range(1, 0) ? CP_TOP + 21'd1
                                       : 21'($urandom_range(21'h1fffff, 21'h110000)), 4);
        if ($urandom_range(1, 0)) append_good_char();
      end
      2: begin
        append_cp($urandom_range(1, 0) ? ($urandom_range(1, 0) ? SURR_FIRST : SURR_LAST)
                                       : 21'($urandom_range(SURR_LAST, SURR_FIRST)), 3);
        if ($urandom_range(1, 0)) append_good_char();
      end
      3: begin
        append_cp(21'($urandom_range(CP_TOP, 21'h10000)), 4);
        repeat ($urandom_range(3, 1)) void'(msg_q.pop_back());
      end
      4: msg_q[$urandom_range(msg_q.size() - 1, 0)] = 8'($urandom_range(255, 0));
      5: msg_q.insert($urandom_range(msg_q.size(), 0), 8'h00);
      6: begin
        msg_q.delete();
        repeat ($urandom_range(8, 1)) msg_q.push_back(8'($urandom_range(255, 0)));
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    while (verdict_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    gaps_on = 1'b0;
    rx_mode = RX_FREE;
    msg_q = '{8'h7f};                      send_message();
    msg_q = '{8'h00};                      send_message();
    msg_q = '{8'h80};                      send_message();
    msg_q = '{8'hff};                      send_message();
    msg_q = '{8'hc2, 8'h80};               send_message();
    // overlong two-byte form
    msg_q = '{8'hc1, 8'hbf};               send_message();
    msg_q = '{8'hed, 8'ha0, 8'h80};        send_message();
    msg_q = '{8'hf4, 8'h90, 8'h80, 8'h80}; send_message();
    // zero where a continuation belongs
    msg_q = '{8'hc3, 8'h00};               send_message();
    msg_q = '{8'he2, 8'h82};               send_message();
    msg_q = '{8'hf4, 8'h8f, 8'hbf, 8'hbf}; send_message();
  endtask

  task automatic test_random_with_stalls(input int byte_budget);
    int start;
    start = bytes_sent;
    gaps_on = 1'b1;
    rx_mode = RX_PATTERN;
    while (bytes_sent - start < byte_budget) begin
      build_message(10);
      send_message();
    end
  endtask

  task automatic test_back_pressure();
    gaps_on = 1'b0;
    rx_mode = RX_FREE;
    hold_seq++;
    repeat (40) begin
      build_message(1);
      send_message();
    end
  endtask

  task automatic test_streaming_no_idle(input int byte_budget);
    int start;
    start = bytes_sent;
    gaps_on = 1'b0;
    rx_mode = RX_FREE;
    while (bytes_sent - start < byte_budget) begin
      build_message(20);
      send_message();
    end
  endtask

  // result side: check the transfer at this edge, then choose the next pop
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual message_valid %0b",
                   $time, message_valid);
        end else begin
          expected_verdict = verdict_q.pop_front();
          verdicts_checked++;
          if (message_valid !== expected_verdict) begin
            fail_count++;
            $display("%0t: message_valid expected %0b actual %0b",
                     $time, expected_verdict, message_valid);
          end
        end
      end
      if (hold_seq != hold_ack) begin
        hold_ack  = hold_seq;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_mode == RX_FREE) begin
        pop <= 1'b1;
      end else begin
        pop        <= rx_pattern[0];
        rx_pattern <= (rx_tick == 5'd31) ? (16'($urandom()) | 16'h0001)
                                         : {rx_pattern[0], rx_pattern[15:1]};
        rx_tick    <= rx_tick + 5'd1;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    push           = 1'b0;
    pop            = 1'b0;
    text_byte      = 8'h00;
    end_of_message = 1'b0;
    pend_cnt       = 2'd0;
    cp_acc         = 21'd0;
    min_sel        = MIN_NONE;
    err_flag       = 1'b0;
    fail_count     = 0;
    bytes_sent     = 0;
    msgs_sent      = 0;
    verdicts_checked = 0;
    stall_cycles   = 0;
    burst_left     = 0;
    gaps_on        = 1'b0;
    offering       = 1'b0;
    rx_mode        = RX_FREE;
    hold_seq       = 0;
    hold_ack       = 0;
    hold_left      = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_with_stalls(1000);
    test_back_pressure();
    test_streaming_no_idle(500);

    if (offering) push <= 1'b0;
    wait_drained();
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d expected verdicts never arrived", $time, verdict_q.size());
      fail_count += verdict_q.size();
    end
    $display("run covered %0d bytes in %0d messages, %0d verdicts compared",
             bytes_sent, msgs_sent, verdicts_checked);
    $display("input held off by full for %0d cycles during result-side stalls",
             stall_cycles);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
